[sv/rgb_linear_color_fader_assert.svh]
// Assertion macros shared by the colour fader modules.
// Needs nothing else; rlcf_div and rgb_linear_color_fader include it at their end.
`ifndef RGB_LINEAR_COLOR_FADER_ASSERT_SVH
`define RGB_LINEAR_COLOR_FADER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RLCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RLCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rlcf_pkg.sv]
// Constants, codes and control structs for the linear RGB colour fader.
// Used by rlcf_div, rlcf_step and rgb_linear_color_fader.
package rlcf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COL_W      = 8;
    localparam int LVL_W      = COL_W + FRAC_BITS;
    localparam int DUR_W      = 16;
    localparam int PROD_W     = LVL_W + DUR_W;
    localparam int NUM_CH     = 3;
    localparam int CH_W       = $clog2(NUM_CH);
    localparam int DIV_CNT_W  = $clog2(LVL_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DUR_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FROM_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FROM_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FROM_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TO_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TO_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TO_BLUE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 3'd6;

    // input opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

[sv/rlcf_div.sv]
// Restoring serial divider: one quotient bit per cycle, LVL_W quotient bits a division.
// Depends on rlcf_pkg and rgb_linear_color_fader_assert.svh.
module rlcf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rlcf_pkg::t_div_ctl            i_ctl,
    input  logic [rlcf_pkg::LVL_W-1:0]    i_dividend,
    input  logic [rlcf_pkg::DUR_W-1:0]    i_divisor,
    output rlcf_pkg::t_div_sts            o_sts,
    output logic [rlcf_pkg::LVL_W-1:0]    o_quot
);
    import rlcf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DUR_W-1:0]     r_rem;
    logic [DUR_W-1:0]     r_dvs;
    logic [LVL_W-1:0]     r_quo;

    logic [DUR_W:0]       rem_sh;
    logic [DUR_W:0]       rem_sub;
    logic                 q_bit;

    assign rem_sh  = {r_rem, r_quo[LVL_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_bit   = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(LVL_W);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // shift the next dividend bit in, keep the quotient bit
                r_rem <= q_bit ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
                r_quo <= {r_quo[LVL_W-2:0], q_bit};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quo;

`include "rgb_linear_color_fader_assert.svh"

    `RLCF_ASSERT_NEXT(a_div_start_busy, i_clk, i_rst_n, i_ctl.start, r_busy && r_cnt == DIV_CNT_W'(LVL_W), "divider did not start")
    `RLCF_ASSERT_NOW(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")
    `RLCF_ASSERT_NEXT(a_div_last_done, i_clk, i_rst_n, r_busy && r_cnt == DIV_CNT_W'(1) && !i_ctl.start, r_done, "divider missed its last step")

endmodule

[sv/rlcf_step.sv]
// Tick update of one channel: saturate the rate*time product, step towards
// the goal and clamp there. Depends on rlcf_pkg.
module rlcf_step (
    input  logic [rlcf_pkg::LVL_W-1:0]  i_level,
    input  logic [rlcf_pkg::LVL_W-1:0]  i_goal,
    input  logic [rlcf_pkg::PROD_W-1:0] i_prod,
    output logic [rlcf_pkg::LVL_W-1:0]  o_level
);
    import rlcf_pkg::*;

    logic [LVL_W-1:0] delta;
    logic [LVL_W:0]   sum;
    logic [LVL_W-1:0] gap;
    logic [LVL_W-1:0] up_lvl;
    logic [LVL_W-1:0] down_lvl;

    assign delta    = (|i_prod[PROD_W-1:LVL_W]) ? '1 : i_prod[LVL_W-1:0];
    assign sum      = {1'b0, i_level} + {1'b0, delta};
    assign up_lvl   = (sum > {1'b0, i_goal}) ? i_goal : sum[LVL_W-1:0];
    assign gap      = i_level - i_goal;
    assign down_lvl = (delta >= gap) ? i_goal : i_level - delta;

    always_comb begin
        priority if (i_level < i_goal) begin
            o_level = up_lvl;
        end else if (i_level > i_goal) begin
            o_level = down_lvl;
        end else begin
            o_level = i_level;
        end
    end

endmodule

[sv/rgb_linear_color_fader.sv]
// Linear RGB colour fader: configuration registers, channel state and sequencer.
// Depends on rlcf_pkg, rlcf_div, rlcf_step and rgb_linear_color_fader_assert.svh.
//
//  channel   direction  handshake                 payload
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//  item      in         i_in_valid / o_in_stall   i_opcode, i_elapsed_time
//  result    out        o_out_valid / i_out_stall o_red, o_green, o_blue, o_done_res
//
// One item at a time; o_in_stall is high whenever the sequencer is not idle.
// Start: each channel's rate comes from the serial divider (one rate bit a cycle),
// channel after channel; a zero duration start skips the divider.
// Tick: a moving channel is multiplied and updated, a stopped one skipped; then output.
// A stalled result holds in the output register; the block finishes the next item
// and waits there. Synchronous active-low reset: all levels 0, all channels stopped.
module rgb_linear_color_fader (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rlcf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rlcf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [rlcf_pkg::DUR_W-1:0]        i_elapsed_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rlcf_pkg::COL_W-1:0]        o_red,
    output logic [rlcf_pkg::COL_W-1:0]        o_green,
    output logic [rlcf_pkg::COL_W-1:0]        o_blue,
    output logic                              o_done_res
);
    import rlcf_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV_GO   = 3'd1;
    localparam logic [2:0] S_DIV_WAIT = 3'd2;
    localparam logic [2:0] S_MUL      = 3'd3;
    localparam logic [2:0] S_UPD      = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

    // configuration
    logic [COL_W-1:0]  r_from [NUM_CH];
    logic [COL_W-1:0]  r_to   [NUM_CH];
    logic [DUR_W-1:0]  r_dur;

    // channel state
    logic [LVL_W-1:0]  r_level  [NUM_CH];
    logic [LVL_W-1:0]  r_rate   [NUM_CH];
    logic [COL_W-1:0]  r_target [NUM_CH];

    // sequencer
    logic [2:0]        r_state;
    logic [CH_W-1:0]   r_ch;
    logic              r_op;
    logic [DUR_W-1:0]  r_elapsed;
    logic [PROD_W-1:0] r_prod;

    // result register
    logic              r_out_valid;
    logic [COL_W-1:0]  r_red;
    logic [COL_W-1:0]  r_green;
    logic [COL_W-1:0]  r_blue;
    logic              r_done_res;

    logic [COL_W-1:0]  from_sel;
    logic [COL_W-1:0]  to_sel;
    logic [COL_W-1:0]  diff;
    logic [LVL_W-1:0]  goal;
    logic [LVL_W-1:0]  step_level;
    logic [LVL_W-1:0]  quot;
    logic [LVL_W-1:0]  rate_new;
    logic              last_ch;
    logic [2:0]        loop_state;
    logic              in_take;
    logic              out_free;
    t_div_ctl          div_ctl;
    t_div_sts          div_sts;

    assign from_sel   = r_from[r_ch];
    assign to_sel     = r_to[r_ch];
    assign diff       = (to_sel > from_sel) ? to_sel - from_sel : from_sel - to_sel;
    assign goal       = {r_target[r_ch], {FRAC_BITS{1'b0}}};
    // a non-zero difference never gets a zero rate
    assign rate_new   = (quot == '0 && diff != '0) ? LVL_W'(1) : quot;
    assign last_ch    = (r_ch == CH_LAST);
    assign loop_state = (r_op == OP_START) ? S_DIV_GO : S_MUL;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign div_ctl.start = (r_state == S_DIV_GO) && (r_dur != '0);

    rlcf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend ({diff, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r_dur),
        .o_sts      (div_sts),
        .o_quot     (quot)
    );

    rlcf_step u_step (
        .i_level (r_level[r_ch]),
        .i_goal  (goal),
        .i_prod  (r_prod),
        .o_level (step_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_from[i] <= '0;
                r_to[i]   <= '0;
            end
            r_dur <= DUR_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FROM_RED:   r_from[0] <= i_cfg_data[COL_W-1:0];
                REG_FROM_GREEN: r_from[1] <= i_cfg_data[COL_W-1:0];
                REG_FROM_BLUE:  r_from[2] <= i_cfg_data[COL_W-1:0];
                REG_TO_RED:     r_to[0]   <= i_cfg_data[COL_W-1:0];
                REG_TO_GREEN:   r_to[1]   <= i_cfg_data[COL_W-1:0];
                REG_TO_BLUE:    r_to[2]   <= i_cfg_data[COL_W-1:0];
                REG_DURATION:   r_dur     <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_level[i]  <= '0;
                r_rate[i]   <= '0;
                r_target[i] <= '0;
            end
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_op        <= OP_TICK;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT loads the next beat itself
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_op      <= i_opcode;
                        r_elapsed <= i_elapsed_time;
                        r_ch      <= '0;
                        r_state   <= (i_opcode == OP_START) ? S_DIV_GO : S_MUL;
                    end
                end
                S_DIV_GO: begin
                    r_target[r_ch] <= to_sel;
                    if (r_dur == '0) begin
                        // jump straight to the target
                        r_level[r_ch] <= {to_sel, {FRAC_BITS{1'b0}}};
                        r_rate[r_ch]  <= '0;
                        r_ch          <= last_ch ? r_ch : r_ch + CH_W'(1);
                        r_state       <= last_ch ? S_OUT : loop_state;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_sts.done) begin
                        r_rate[r_ch]  <= rate_new;
                        r_level[r_ch] <= {from_sel, {FRAC_BITS{1'b0}}};
                        r_ch          <= last_ch ? r_ch : r_ch + CH_W'(1);
                        r_state       <= last_ch ? S_OUT : loop_state;
                    end
                end
                S_MUL: begin
                    if (r_rate[r_ch] == '0) begin
                        // stopped channel: skip
                        r_ch    <= last_ch ? r_ch : r_ch + CH_W'(1);
                        r_state <= last_ch ? S_OUT : loop_state;
                    end else begin
                        r_prod  <= PROD_W'(r_rate[r_ch]) * PROD_W'(r_elapsed);
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_level[r_ch] <= step_level;
                    if (step_level == goal) begin
                        r_rate[r_ch] <= '0;
                    end
                    r_ch    <= last_ch ? r_ch : r_ch + CH_W'(1);
                    r_state <= last_ch ? S_OUT : loop_state;
                end
                S_OUT: begin
                    // hold until the previous beat has gone
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_red       <= r_level[0][LVL_W-1:FRAC_BITS];
                        r_green     <= r_level[1][LVL_W-1:FRAC_BITS];
                        r_blue      <= r_level[2][LVL_W-1:FRAC_BITS];
                        r_done_res  <= (r_rate[0] == '0) && (r_rate[1] == '0)
                                       && (r_rate[2] == '0);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_done_res  = r_done_res;

`include "rgb_linear_color_fader_assert.svh"

    `RLCF_ASSERT_NEXT(a_take_leaves_idle, i_clk, i_rst_n, in_take, r_state != S_IDLE, "accepted beat left sequencer idle")
    `RLCF_ASSERT_NOW(a_div_done_waited, i_clk, i_rst_n, div_sts.done, r_state == S_DIV_WAIT, "divider result arrived unexpectedly")
    `RLCF_ASSERT_NOW(a_div_start_free, i_clk, i_rst_n, div_ctl.start, !div_sts.busy, "divider started while busy")

endmodule
